// ===== src/tbs_pkg.sv =====
`timescale 1ns / 1ps

package tbs_pkg;

  // waiting queue geometry
  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned LVL_W       = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int unsigned TAG_W   = 32;
  localparam int unsigned NEED_W  = 16;
  localparam int unsigned TOKEN_W = 16;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned ENTRY_W = TAG_W + NEED_W;

  // stream payload widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = ((ENTRY_W + 7) / 8) * 8;
  localparam int unsigned OUT_RAW_W  = TAG_W + NEED_W + TOKEN_W + LVL_W + 2 * CNT_W;
  localparam int unsigned OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int unsigned OUT_USER_W = 4;

  localparam logic [TOKEN_W-1:0] BUCKET_DEPTH_RESET = TOKEN_W'(10);

  typedef enum logic {
    OP_ARRIVAL = 1'b0,
    OP_TICK    = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_QUEUED        = 3'd0,
    ST_OVERSIZED     = 3'd1,
    ST_QFULL         = 3'd2,
    ST_TOKEN_ADDED   = 3'd3,
    ST_TOKEN_DROPPED = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [NEED_W-1:0] need;
    logic [TAG_W-1:0]  tag;
  } entry_t;

endpackage

// ===== src/tbs_ram.sv =====
`timescale 1ns / 1ps

module tbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/token_bucket_packet_shaper.sv =====
`timescale 1ns / 1ps

// token bucket shaper with a waiting packet queue
//
// input stream (s_axis): one request per item; tuser[0] selects a packet
// arrival (0) or a token tick (1), tdata carries the packet tag and its
// token need. output stream (m_axis): exactly one result request per input
// request, with the status, the departing head packet if any, and snapshots
// of the bucket, queue level and drop counters.
// config channel (cfg_*): writes bucket_depth; always ready, to be used
// only while the block is idle.
//
// the block takes a new item only in the idle state, after the last item has
// left execute. the idle state admits the item and pushes it into the queue
// ram; the execute state uses the head entry read from the registered ram
// port to decide the departure. the result is valid on the cycle after execute.
// a stalled receiver holds the result in the output register; the next item
// is still taken and waits in the execute cycle until the register frees.
// reset clears bucket, pointers, level and counters; bucket_depth returns to
// 10. queue ram contents are not cleared, only written entries are read.

module token_bucket_packet_shaper (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [31:0] packet_tag, [47:32] tokens_needed
  input  logic [tbs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [0] operation
  input  logic                            s_axis_tuser,

  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] moved_tag, [47:32] moved_need, [63:48] tokens_now,
  // [48+LVL_W+15:64] queue_level, then dropped_packet_count,
  // then dropped_token_count, zero padding on top
  output logic [tbs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // [2:0] status, [3] moved_valid
  output logic [tbs_pkg::OUT_USER_W-1:0]  m_axis_tuser,

  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tbs_pkg::TOKEN_W-1:0]     cfg_wdata_i
);

  localparam int unsigned PTR_W   = tbs_pkg::PTR_W;
  localparam int unsigned LVL_W   = tbs_pkg::LVL_W;
  localparam int unsigned TAG_W   = tbs_pkg::TAG_W;
  localparam int unsigned NEED_W  = tbs_pkg::NEED_W;
  localparam int unsigned TOKEN_W = tbs_pkg::TOKEN_W;
  localparam int unsigned CNT_W   = tbs_pkg::CNT_W;

  localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(tbs_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(tbs_pkg::QUEUE_DEPTH - 1);

  // architectural state
  logic [TOKEN_W-1:0] depth_q;
  logic [TOKEN_W-1:0] token_q, token_d;
  logic [PTR_W-1:0]   head_q, head_d;
  logic [PTR_W-1:0]   tail_q, tail_d;
  logic [LVL_W-1:0]   level_q, level_d;
  logic [CNT_W-1:0]   pdrop_q, pdrop_d;
  logic [CNT_W-1:0]   tdrop_q, tdrop_d;

  tbs_pkg::state_e state_q, state_d;

  // item held between admit and execute
  tbs_pkg::entry_t  item_q;
  tbs_pkg::status_e stat_q, stat_d;
  logic             attempt_q, attempt_d;
  logic             empty_q;

  // output register
  logic                 out_valid_q, out_valid_d;
  tbs_pkg::status_e     o_stat_q;
  logic                 o_moved_q;
  logic [TAG_W-1:0]     o_tag_q;
  logic [NEED_W-1:0]    o_need_q;
  logic [TOKEN_W-1:0]   o_token_q;
  logic [LVL_W-1:0]     o_level_q;
  logic [CNT_W-1:0]     o_pdrop_q;
  logic [CNT_W-1:0]     o_tdrop_q;

  // handshake and datapath signals
  logic             in_acc;
  logic             commit;
  logic             push;
  logic             release_ok;
  tbs_pkg::op_e     in_op;
  tbs_pkg::entry_t  in_entry;
  tbs_pkg::entry_t  ram_rdata;
  tbs_pkg::entry_t  head_entry;

  assign in_op    = tbs_pkg::op_e'(s_axis_tuser);
  assign in_entry = s_axis_tdata[tbs_pkg::ENTRY_W-1:0];
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  assign cfg_ready_o = 1'b1;

  // queue storage, head is read every cycle
  tbs_ram #(
    .WIDTH (tbs_pkg::ENTRY_W),
    .DEPTH (tbs_pkg::QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (tail_q),
    .wdata_i (in_entry),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // a packet pushed into an empty queue is the head before the ram shows it
  assign head_entry = empty_q ? item_q : ram_rdata;
  assign release_ok = attempt_q && (level_q != '0) && (token_q >= head_entry.need);

  always_comb begin
    state_d     = state_q;
    token_d     = token_q;
    head_d      = head_q;
    tail_d      = tail_q;
    level_d     = level_q;
    pdrop_d     = pdrop_q;
    tdrop_d     = tdrop_q;
    stat_d      = stat_q;
    attempt_d   = attempt_q;
    out_valid_d = out_valid_q;
    push        = 1'b0;
    commit      = 1'b0;
    s_axis_tready = 1'b0;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      tbs_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d   = tbs_pkg::S_EXEC;
          attempt_d = 1'b0;
          case (in_op)
            tbs_pkg::OP_ARRIVAL: begin
              if (in_entry.need > depth_q) begin
                pdrop_d = pdrop_q + 1'b1;
                stat_d  = tbs_pkg::ST_OVERSIZED;
              end else if (level_q == LVL_FULL) begin
                pdrop_d   = pdrop_q + 1'b1;
                stat_d    = tbs_pkg::ST_QFULL;
                attempt_d = 1'b1;
              end else begin
                push      = 1'b1;
                tail_d    = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
                level_d   = level_q + 1'b1;
                stat_d    = tbs_pkg::ST_QUEUED;
                attempt_d = 1'b1;
              end
            end
            tbs_pkg::OP_TICK: begin
              if (token_q >= depth_q) begin
                tdrop_d = tdrop_q + 1'b1;
                stat_d  = tbs_pkg::ST_TOKEN_DROPPED;
              end else begin
                token_d   = token_q + 1'b1;
                stat_d    = tbs_pkg::ST_TOKEN_ADDED;
                attempt_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      tbs_pkg::S_EXEC: begin
        // wait here while the output register is still full
        if (!out_valid_q || m_axis_tready) begin
          commit      = 1'b1;
          out_valid_d = 1'b1;
          state_d     = tbs_pkg::S_IDLE;
          if (release_ok) begin
            token_d = token_q - head_entry.need;
            head_d  = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
            level_d = level_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = tbs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tbs_pkg::S_IDLE;
      depth_q     <= tbs_pkg::BUCKET_DEPTH_RESET;
      token_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      level_q     <= '0;
      pdrop_q     <= '0;
      tdrop_q     <= '0;
      attempt_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      token_q     <= token_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      level_q     <= level_d;
      pdrop_q     <= pdrop_d;
      tdrop_q     <= tdrop_d;
      attempt_q   <= attempt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        depth_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    stat_q <= stat_d;
    if (in_acc) begin
      item_q  <= in_entry;
      empty_q <= (level_q == '0);
    end
    if (commit) begin
      o_stat_q  <= stat_q;
      o_moved_q <= release_ok;
      o_tag_q   <= release_ok ? head_entry.tag  : '0;
      o_need_q  <= release_ok ? head_entry.need : '0;
      o_token_q <= token_d;
      o_level_q <= level_d;
      o_pdrop_q <= pdrop_q;
      o_tdrop_q <= tdrop_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = {o_moved_q, o_stat_q};

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[TAG_W-1:0]                      = o_tag_q;
    m_axis_tdata[TAG_W +: NEED_W]                = o_need_q;
    m_axis_tdata[TAG_W+NEED_W +: TOKEN_W]        = o_token_q;
    m_axis_tdata[TAG_W+NEED_W+TOKEN_W +: LVL_W]  = o_level_q;
    m_axis_tdata[TAG_W+NEED_W+TOKEN_W+LVL_W +: CNT_W]       = o_pdrop_q;
    m_axis_tdata[TAG_W+NEED_W+TOKEN_W+LVL_W+CNT_W +: CNT_W] = o_tdrop_q;
  end

  // queue level never goes past the queue depth
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LVL_FULL)
    else $error("queue level beyond depth");

  // an empty or full queue has coinciding pointers
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_q == '0 || level_q == LVL_FULL) |-> (head_q == tail_q))
    else $error("queue pointers out of step with level");

  // a departure takes exactly one packet off the queue
  a_release_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && release_ok) |=> (level_q == $past(level_q) - 1'b1))
    else $error("departure did not pop the queue");

  // an accepted request always reaches the execute cycle next
  a_admit_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == tbs_pkg::S_EXEC))
    else $error("accepted request skipped execute");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned HALF_PERIOD   = 6;
  localparam int unsigned RUN_LIMIT     = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS   = 186;
  localparam int unsigned DIR_ROWS      = 23;
  localparam int unsigned DEPTH_MAX     = 65535;

  localparam int unsigned PTR_W   = tbs_pkg::PTR_W;
  localparam int unsigned LVL_W   = tbs_pkg::LVL_W;
  localparam int unsigned TAG_W   = tbs_pkg::TAG_W;
  localparam int unsigned NEED_W  = tbs_pkg::NEED_W;
  localparam int unsigned TOKEN_W = tbs_pkg::TOKEN_W;
  localparam int unsigned CNT_W   = tbs_pkg::CNT_W;

  // bit offsets of the result fields in m_axis_tdata
  localparam int unsigned O_NEED   = TAG_W;
  localparam int unsigned O_TOKENS = O_NEED + NEED_W;
  localparam int unsigned O_LEVEL  = O_TOKENS + TOKEN_W;
  localparam int unsigned O_PDROP  = O_LEVEL + LVL_W;
  localparam int unsigned O_TDROP  = O_PDROP + CNT_W;

  typedef struct packed {
    tbs_pkg::status_e    status;
    logic                moved;
    logic [TAG_W-1:0]    tag;
    logic [NEED_W-1:0]   need;
    logic [TOKEN_W-1:0]  tokens;
    logic [LVL_W-1:0]    level;
    logic [CNT_W-1:0]    pkt_drops;
    logic [CNT_W-1:0]    tok_drops;
  } shaper_result_t;

  // values typed into the directed table, checked on top of the prediction
  typedef struct packed {
    logic                on;
    tbs_pkg::status_e    status;
    logic                moved;
    logic [TOKEN_W-1:0]  tokens;
    logic [LVL_W-1:0]    level;
  } pinned_t;

  typedef enum logic {
    ROW_ITEM  = 1'b0,
    ROW_DEPTH = 1'b1
  } row_kind_e;

  // for a ROW_DEPTH row the need column holds the new bucket depth
  typedef struct packed {
    row_kind_e           kind;
    tbs_pkg::op_e        op;
    logic [TAG_W-1:0]    tag;
    logic [NEED_W-1:0]   need;
    logic                pinned;
    tbs_pkg::status_e    status;
    logic                moved;
    logic [TOKEN_W-1:0]  tokens;
    logic [LVL_W-1:0]    level;
  } row_t;

  logic                               clk_i;
  logic                               rst_ni        = 1'b0;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [tbs_pkg::IN_DATA_W-1:0]      s_axis_tdata  = '0;
  logic                               s_axis_tuser  = 1'b0;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [tbs_pkg::OUT_DATA_W-1:0]     m_axis_tdata;
  logic [tbs_pkg::OUT_USER_W-1:0]     m_axis_tuser;
  logic                               cfg_valid_i   = 1'b0;
  logic                               cfg_ready_o;
  logic [TOKEN_W-1:0]                 cfg_wdata_i   = '0;

  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 78;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;

  shaper_result_t expected_results[$];
  pinned_t        pinned_results[$];

  // shadow of the shaper state
  logic [TOKEN_W-1:0] bkt_depth  = tbs_pkg::BUCKET_DEPTH_RESET;
  logic [TOKEN_W-1:0] bkt_tokens = '0;
  tbs_pkg::entry_t    wait_q [tbs_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   q_head     = '0;
  logic [PTR_W-1:0]   q_tail     = '0;
  logic [LVL_W-1:0]   q_level    = '0;
  logic [CNT_W-1:0]   pkt_drops  = '0;
  logic [CNT_W-1:0]   tok_drops  = '0;

  // reset depth is 10; the rows walk the special cases, then depths 1 and 65535
  row_t dir_rows [DIR_ROWS] = '{
    '{ROW_ITEM, tbs_pkg::OP_TICK, 32'h0000_0000, 16'd0,
      1'b1, tbs_pkg::ST_TOKEN_ADDED, 1'b0, 16'd1, 7'd0},
    '{ROW_ITEM, tbs_pkg::OP_ARRIVAL, 32'hFFFF_FFFF, 16'd11,
      1'b1, tbs_pkg::ST_OVERSIZED, 1'b0, 16'd1, 7'd0},
    '{ROW_ITEM, tbs_pkg::OP_ARRIVAL, 32'h0000_0000, 16'd0,
      1'b1, tbs_pkg::ST_QUEUED, 1'b1, 16'd1, 7'd0},
    '{ROW_ITEM, tbs_pkg::OP_ARRIVAL, 32'h5A5A_5A5A, 16'd10,
      1'b1, tbs_pkg::ST_QUEUED, 1'b0, 16'd1, 7'd1},
    '{ROW_ITEM, tbs_pkg::OP_ARRIVAL, 32'h1234_5678, 16'hFFFF,
      1'b1, tbs_pkg::ST_OVERSIZED, 1'b0, 16'd1, 7'd1},
    '{ROW_ITEM, tbs_pkg::OP_ARRIVAL, 32'h0000_FFFF, 16'd3,
      1'b0, tbs_pkg::ST_QUEUED, 1'b0, 16'd0, 7'd0},
    '{ROW_DEPTH, tbs_pkg::OP_TICK, 32'h0000_0000, 16'd1,
      1'b0, tbs_pkg::ST_QUEUED, 1'b0, 16'd0, 7'd0},
    '{ROW_ITEM, tbs_pkg::OP_TICK, 32'h0000_0000, 16'd0,
      1'b1, tbs_pkg::ST_TOKEN_DROPPED, 1'b0, 16'd1, 7'd2},
    '{ROW_ITEM, tbs_pkg::OP_ARRIVAL, 32'hC3C3_3C3C, 16'd2,
      1'b1, tbs_pkg::ST_OVERSIZED, 1'b0, 16'd1, 7'd2},
    '{ROW_DEPTH, tbs_pkg::OP_TICK, 32'h0000_0000, 16'hFFFF,
      1'b0, tbs_pkg::ST_QUEUED, 1'b0, 16'd0, 7'd0},
    '{ROW_ITEM, tbs_pkg::OP_TICK, 32'h0000_0000, 16'd0,
      1'b0, tbs_pkg::ST_QUEUED, 1'b0, 16'd0, 7'd0},
    '{ROW_ITEM, tbs_pkg::OP_TICK, 32'hFFFF_FFFF, 16'hFFFF,
      1'b0, tbs_pkg::ST_QUEUED, 1'b0, 16'd0, 7'd0},
    '{ROW_ITEM, tbs_pkg::OP_TICK, 32'h0000_0000, 16'd0,
      1'b0, tbs_pkg::ST_QUEUED, 1'b0, 16'd0, 7'd0},
    '{ROW_ITEM, tbs_pkg::OP_TICK, 32'h0000_0000, 16'd0,
      1'b0, tbs_pkg::ST_QUEUED, 1'b0, 16'd0, 7'd0},
    '{ROW_ITEM, tbs_pkg::OP_TICK, 32'h0000_0000, 16'd0,
      1'b0, tbs_pkg::ST_QUEUED, 1'b0, 16'd0, 7'd0},
    '{ROW_ITEM, tbs_pkg::OP_TICK, 32'h0000_0000, 16'd0,
      1'b0, tbs_pkg::ST_QUEUED, 1'b0, 16'd0, 7'd0},
    '{ROW_ITEM, tbs_pkg::OP_TICK, 32'h0000_0000, 16'd0,
      1'b0, tbs_pkg::ST_QUEUED, 1'b0, 16'd0, 7'd0},
    '{ROW_ITEM, tbs_pkg::OP_TICK, 32'h0000_0000, 16'd0,
      1'b0, tbs_pkg::ST_QUEUED, 1'b0, 16'd0, 7'd0},
    '{ROW_ITEM, tbs_pkg::OP_TICK, 32'h0000_0000, 16'd0,
      1'b0, tbs_pkg::ST_QUEUED, 1'b0, 16'd0, 7'd0},
    '{ROW_ITEM, tbs_pkg::OP_TICK, 32'h0000_0000, 16'd0,
      1'b0, tbs_pkg::ST_QUEUED, 1'b0, 16'd0, 7'd0},
    '{ROW_ITEM, tbs_pkg::OP_TICK, 32'h0000_0000, 16'd0,
      1'b0, tbs_pkg::ST_QUEUED, 1'b0, 16'd0, 7'd0},
    '{ROW_ITEM, tbs_pkg::OP_TICK, 32'h0000_0000, 16'd0,
      1'b0, tbs_pkg::ST_QUEUED, 1'b0, 16'd0, 7'd0},
    '{ROW_ITEM, tbs_pkg::OP_ARRIVAL, 32'hFFFF_FFFF, 16'd0,
      1'b0, tbs_pkg::ST_QUEUED, 1'b0, 16'd0, 7'd0}
  };

  token_bucket_packet_shaper dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #HALF_PERIOD clk_i = ~clk_i;
  end

  // admit, queue, refill or drop, then try to release the head packet
  function automatic shaper_result_t shape_step(tbs_pkg::op_e op, logic [TAG_W-1:0] tag,
                                                logic [NEED_W-1:0] need);
    shaper_result_t r;
    logic attempt;
    r.status = tbs_pkg::ST_QUEUED;
    r.moved  = 1'b0;
    r.tag    = '0;
    r.need   = '0;
    attempt  = 1'b0;
    if (op == tbs_pkg::OP_ARRIVAL) begin
      if (need > bkt_depth) begin
        pkt_drops++;
        r.status = tbs_pkg::ST_OVERSIZED;
      end else begin
        if (q_level >= tbs_pkg::QUEUE_DEPTH) begin
          pkt_drops++;
          r.status = tbs_pkg::ST_QFULL;
        end else begin
          wait_q[q_tail].tag  = tag;
          wait_q[q_tail].need = need;
          q_tail++;
          q_level++;
        end
        attempt = 1'b1;
      end
    end else begin
      if (bkt_tokens >= bkt_depth) begin
        tok_drops++;
        r.status = tbs_pkg::ST_TOKEN_DROPPED;
      end else begin
        bkt_tokens++;
        r.status = tbs_pkg::ST_TOKEN_ADDED;
        attempt  = 1'b1;
      end
    end
    if (attempt && q_level != 0 && bkt_tokens >= wait_q[q_head].need) begin
      r.moved    = 1'b1;
      r.tag      = wait_q[q_head].tag;
      r.need     = wait_q[q_head].need;
      bkt_tokens = bkt_tokens - wait_q[q_head].need;
      q_head++;
      q_level--;
    end
    r.tokens    = bkt_tokens;
    r.level     = q_level;
    r.pkt_drops = pkt_drops;
    r.tok_drops = tok_drops;
    return r;
  endfunction

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    shaper_result_t want;
    pinned_t        pin;
    if (expected_results.size() == 0) begin
      $error("result request with nothing outstanding");
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      pin  = pinned_results.pop_front();
      compare_field("status", 64'(want.status), 64'(m_axis_tuser[2:0]));
      compare_field("moved_valid", 64'(want.moved), 64'(m_axis_tuser[3]));
      compare_field("moved_tag", 64'(want.tag), 64'(m_axis_tdata[0 +: TAG_W]));
      compare_field("moved_need", 64'(want.need), 64'(m_axis_tdata[O_NEED +: NEED_W]));
      compare_field("tokens_now", 64'(want.tokens),
                    64'(m_axis_tdata[O_TOKENS +: TOKEN_W]));
      compare_field("queue_level", 64'(want.level), 64'(m_axis_tdata[O_LEVEL +: LVL_W]));
      compare_field("dropped_packet_count", 64'(want.pkt_drops),
                    64'(m_axis_tdata[O_PDROP +: CNT_W]));
      compare_field("dropped_token_count", 64'(want.tok_drops),
                    64'(m_axis_tdata[O_TDROP +: CNT_W]));
      if (pin.on) begin
        compare_field("status (table)", 64'(pin.status), 64'(m_axis_tuser[2:0]));
        compare_field("moved_valid (table)", 64'(pin.moved), 64'(m_axis_tuser[3]));
        compare_field("tokens_now (table)", 64'(pin.tokens),
                      64'(m_axis_tdata[O_TOKENS +: TOKEN_W]));
        compare_field("queue_level (table)", 64'(pin.level),
                      64'(m_axis_tdata[O_LEVEL +: LVL_W]));
      end
    end
  endtask

  // receiver: random backpressure, result checked on every accepted request
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result();
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("token_bucket_packet_shaper: mismatch");
      $finish;
    end
  end

  task automatic send_request(tbs_pkg::op_e op, logic [TAG_W-1:0] tag,
                              logic [NEED_W-1:0] need, pinned_t pin);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {need, tag};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(shape_step(op, tag, need));
    pinned_results.push_back(pin);
  endtask

  // hold off the sender until every outstanding result is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_depth(int unsigned depth);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= TOKEN_W'(depth);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    bkt_depth = TOKEN_W'(depth);
  endtask

  task automatic run_phase(int unsigned depth, int unsigned tick_pct, int unsigned need_cap,
                           int unsigned s_pct, int unsigned r_pct);
    tbs_pkg::op_e      op;
    logic [NEED_W-1:0] need;
    int unsigned       sel;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    write_depth(depth);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      op  = ($urandom_range(99) < tick_pct) ? tbs_pkg::OP_TICK : tbs_pkg::OP_ARRIVAL;
      sel = $urandom_range(99);
      // oversized needs range from one above the depth up to 65535; a need of exactly the depth
      // only where the bucket can fill within a phase
      if (depth < DEPTH_MAX && sel < 10)
        need = NEED_W'($urandom_range(DEPTH_MAX, depth + 1));
      else if (depth <= 10 && sel < 15)
        need = NEED_W'(depth);
      else
        need = NEED_W'($urandom_range(need_cap));
      if ($urandom_range(39) == 0) drain_results();
      send_request(op, $urandom, need, '0);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_DEPTH)
        write_depth(32'(dir_rows[i].need));
      else
        send_request(dir_rows[i].op, dir_rows[i].tag, dir_rows[i].need,
                     '{dir_rows[i].pinned, dir_rows[i].status, dir_rows[i].moved,
                       dir_rows[i].tokens, dir_rows[i].level});
    end

    // depth, tick share, need range, sender idle, receiver idle
    run_phase(1,         50, 1,  29, 78);
    run_phase(4,         15, 4,  29, 78);
    run_phase(10,        50, 10, 78, 29);
    run_phase(300,       55, 12, 78, 29);
    run_phase(DEPTH_MAX, 60, 8,  0,  0);

    drain_results();
    if (mismatches == 0 && expected_results.size() == 0)
      $display("token_bucket_packet_shaper: match");
    else
      $display("token_bucket_packet_shaper: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tbs_pkg.sv
src/tbs_ram.sv
src/token_bucket_packet_shaper.sv
test/tb.sv
